FILE: rtl/vsync_field_period_calc_core_assert.svh
// Assertion macros shared by the vsync field period calculator RTL.
`ifndef VSYNC_FIELD_PERIOD_CALC_CORE_ASSERT_SVH
`define VSYNC_FIELD_PERIOD_CALC_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define VFPC_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("vfpc assertion failed");
`define VFPC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("vfpc assertion failed");
`else
`define VFPC_ASSERT_SAME(lbl, ante, cons)
`define VFPC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/vfpc_pkg.sv
// Types and constants of the vsync field period calculator.
package vfpc_pkg;

	localparam int NUM_CHANNELS_DEF = 6;
	localparam int TICK_HZ_DEF      = 27000000;

	localparam int CH_W      = 3;
	localparam int CNT_W     = 32;
	localparam int SHIFT_W   = 16;
	localparam int SHIFT_REGS = 6;
	localparam int DVD_W     = 64;
	localparam int DIV_STEPS = DVD_W;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = SHIFT_W;

	localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_RATE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_FIRST   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_LAST    = 3'd6;

	typedef struct packed {
		logic [CH_W-1:0]  channel;
		logic [CNT_W-1:0] rate_num;
		logic [CNT_W-1:0] rate_den;
		logic             interlaced;
	} vfpc_in_t;

	typedef struct packed {
		logic             ok;
		logic [CH_W-1:0]  out_channel;
		logic [CNT_W-1:0] first_field_count;
		logic [CNT_W-1:0] second_field_count;
		logic             field_select;
		logic             scan_changed;
	} vfpc_out_t;

	typedef struct packed {
		logic busy;
		logic done;
	} vfpc_div_stat_t;

endpackage

FILE: rtl/vfpc_if.sv
// Valid/ready stream interfaces for requests and results.
interface vfpc_in_if;
	logic               valid;
	logic               ready;
	vfpc_pkg::vfpc_in_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface vfpc_out_if;
	logic                valid;
	logic                ready;
	vfpc_pkg::vfpc_out_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/vfpc_div.sv
// Bit-serial restoring divider: 64-bit dividend by 32-bit divisor, low 32 quotient bits.
module vfpc_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [vfpc_pkg::DVD_W-1:0]         dividend,
	input  logic [vfpc_pkg::CNT_W-1:0]         divisor,
	output logic [vfpc_pkg::CNT_W-1:0]         quotient,
	output vfpc_pkg::vfpc_div_stat_t           stat
);
	logic                          busy_q;
	logic                          done_q;
	logic [vfpc_pkg::STEP_W-1:0]   step_q;
	logic [vfpc_pkg::DVD_W-1:0]    dvd_q;
	logic [vfpc_pkg::CNT_W-1:0]    dsr_q;
	logic [vfpc_pkg::CNT_W-1:0]    rem_q;
	logic [vfpc_pkg::CNT_W-1:0]    quo_q;
	logic [vfpc_pkg::CNT_W:0]      rem_sh;
	logic [vfpc_pkg::CNT_W:0]      rem_sub;
	logic                          fits;
	logic                          last_step;

	// The partial remainder stays below the divisor, so 33 bits hold the shifted value.
	always_comb begin
		rem_sh  = {rem_q, dvd_q[vfpc_pkg::DVD_W-1]};
		rem_sub = rem_sh - {1'b0, dsr_q};
		fits    = rem_sh >= {1'b0, dsr_q};
	end

	assign last_step = (step_q == vfpc_pkg::STEP_W'(vfpc_pkg::DIV_STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= !start && busy_q && last_step;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (last_step) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[vfpc_pkg::DVD_W-2:0], 1'b0};
			rem_q <= fits ? rem_sub[vfpc_pkg::CNT_W-1:0] : rem_sh[vfpc_pkg::CNT_W-1:0];
			quo_q <= {quo_q[vfpc_pkg::CNT_W-2:0], fits};
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;
endmodule

FILE: rtl/vfpc_cfg_regs.sv
// Configuration registers: double-rate flag and per-channel phase shifts.
module vfpc_cfg_regs (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [vfpc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [vfpc_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic [vfpc_pkg::CH_W-1:0]            rd_channel,
	output logic                                 double_rate,
	output logic signed [vfpc_pkg::SHIFT_W-1:0]  phase_shift
);
	logic                                double_rate_q;
	logic signed [vfpc_pkg::SHIFT_W-1:0] phase_q [vfpc_pkg::SHIFT_REGS];
	logic [vfpc_pkg::CFG_IDX_W-1:0]      slot;

	assign slot = cfg_index - vfpc_pkg::REG_PHASE_FIRST;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			double_rate_q <= 1'b0;
			for (int i = 0; i < vfpc_pkg::SHIFT_REGS; i++) begin
				phase_q[i] <= '0;
			end
		end else if (cfg_we) begin
			if (cfg_index == vfpc_pkg::REG_DOUBLE_RATE) begin
				double_rate_q <= cfg_data[0];
			end else if (cfg_index >= vfpc_pkg::REG_PHASE_FIRST &&
					cfg_index <= vfpc_pkg::REG_PHASE_LAST) begin
				phase_q[slot] <= cfg_data;
			end
		end
	end

	// Channels without a shift register of their own see no offset.
	always_comb begin
		if (32'(rd_channel) < vfpc_pkg::SHIFT_REGS) begin
			phase_shift = phase_q[rd_channel];
		end else begin
			phase_shift = '0;
		end
	end

	assign double_rate = double_rate_q;
endmodule

FILE: rtl/vsync_field_period_calc_core.sv
// Top level: sequencer around the serial divider, scan-type state and result register.
//
//   channel  direction  accepted when
//   req      in         req.valid && req.ready
//   rsp      out        rsp.valid && rsp.ready
//   cfg      in         cfg_we (index cfg_index, data cfg_data)
//
// A valid request is taken; then the product is loaded into the divider, the divider
// runs its 64 steps (one quotient bit a cycle), the quotient is picked up and the fields
// are finished. req.ready is high only while idle, so a new request is taken only when
// the last is through; a rejected request skips the divider and goes straight to the
// finishing step. A finished result waits while the output register is full, which
// keeps req.ready low; a result that sits in the register does not block a new request.
// arst_n clears control state and sets every channel's scan type to interlaced.
module vsync_field_period_calc_core #(
	parameter int NUM_CHANNELS = vfpc_pkg::NUM_CHANNELS_DEF,
	parameter int TICK_HZ      = vfpc_pkg::TICK_HZ_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	vfpc_in_if.sink                           req,
	vfpc_out_if.source                        rsp,
	input  logic                              cfg_we,
	input  logic [vfpc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [vfpc_pkg::CFG_DATA_W-1:0]   cfg_data
);
	`include "vsync_field_period_calc_core_assert.svh"

	localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DIV,
		ST_FIN
	} state_t;

	state_t                          state_q;
	logic [vfpc_pkg::CH_W-1:0]       ch_q;
	logic [vfpc_pkg::CNT_W-1:0]      num_q;
	logic [vfpc_pkg::CNT_W-1:0]      den_q;
	logic                            intl_q;
	logic                            bad_q;
	logic [vfpc_pkg::CNT_W-1:0]      quo_q;
	logic [NUM_CHANNELS-1:0]         scan_q;
	logic                            rsp_valid_q;
	vfpc_pkg::vfpc_out_t             rsp_data_q;

	logic                            req_take;
	logic                            req_bad;
	logic                            div_start;
	logic [vfpc_pkg::DVD_W-1:0]      product;
	logic [vfpc_pkg::CNT_W-1:0]      div_quo;
	vfpc_pkg::vfpc_div_stat_t        div_stat;
	logic                            double_rate;
	logic signed [vfpc_pkg::SHIFT_W-1:0] phase_shift;
	logic [vfpc_pkg::CNT_W-1:0]      period_sum;
	logic [vfpc_pkg::CNT_W-1:0]      period;
	logic [vfpc_pkg::CNT_W-1:0]      first_cnt;
	logic [vfpc_pkg::CNT_W-1:0]      second_cnt;
	logic                            stored_scan;
	logic                            out_free;
	logic                            out_load;
	vfpc_pkg::vfpc_out_t             result;

	assign req.ready = (state_q == ST_IDLE);
	assign req_take  = req.valid && req.ready;
	assign req_bad   = (32'(req.payload.channel) >= NUM_CHANNELS) ||
		(req.payload.rate_num == '0) || (req.payload.rate_den == '0);

	// The product register is the divider's own dividend register.
	assign div_start = (state_q == ST_LOAD);
	assign product   = 64'(den_q) * 64'(TICK_HZ);

	vfpc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (product),
		.divisor  (num_q),
		.quotient (div_quo),
		.stat     (div_stat)
	);

	vfpc_cfg_regs u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.rd_channel  (ch_q),
		.double_rate (double_rate),
		.phase_shift (phase_shift)
	);

	always_comb begin
		period_sum = quo_q + {{(vfpc_pkg::CNT_W - vfpc_pkg::SHIFT_W){phase_shift[vfpc_pkg::SHIFT_W-1]}},
			phase_shift};
		period     = double_rate ? (period_sum >> 1) : period_sum;
		first_cnt  = period >> 1;
		second_cnt = first_cnt + vfpc_pkg::CNT_W'(period[0]);
		stored_scan = scan_q[ch_q[CH_IDX_W-1:0]];

		result.out_channel = ch_q;
		if (bad_q) begin
			result.ok                 = 1'b0;
			result.first_field_count  = '0;
			result.second_field_count = '0;
			result.field_select       = 1'b0;
			result.scan_changed       = 1'b0;
		end else begin
			result.ok                 = 1'b1;
			result.first_field_count  = first_cnt;
			result.second_field_count = second_cnt;
			result.field_select       = intl_q;
			result.scan_changed       = intl_q != stored_scan;
		end
	end

	assign out_free = !rsp_valid_q || rsp.ready;
	assign out_load = (state_q == ST_FIN) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
			scan_q      <= '1;
		end else begin
			rsp_valid_q <= out_load || (rsp_valid_q && !rsp.ready);
			unique case (state_q)
				ST_IDLE: begin
					if (req_take) begin
						state_q <= req_bad ? ST_FIN : ST_LOAD;
					end
				end
				ST_LOAD: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_stat.done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						if (!bad_q) begin
							scan_q[ch_q[CH_IDX_W-1:0]] <= intl_q;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_take) begin
			ch_q   <= req.payload.channel;
			num_q  <= req.payload.rate_num;
			den_q  <= req.payload.rate_den;
			intl_q <= req.payload.interlaced;
			bad_q  <= req_bad;
		end
		if (div_stat.done) begin
			quo_q <= div_quo;
		end
		if (out_load) begin
			rsp_data_q <= result;
		end
	end

	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_data_q;

	`VFPC_ASSERT_NEXT(a_busy_after_take, req_take, !req.ready)
	`VFPC_ASSERT_SAME(a_div_start_idle, div_start, !div_stat.busy)
	`VFPC_ASSERT_SAME(a_done_in_div, div_stat.done, state_q == ST_DIV)
	`VFPC_ASSERT_SAME(a_reject_zero, rsp.valid && !rsp.payload.ok,
		rsp.payload.first_field_count == '0 && rsp.payload.second_field_count == '0 &&
		!rsp.payload.scan_changed)
endmodule
